FILE: rtl/s20sc_pkg.sv
// Shared types, constants and helper functions for the Salsa20 byte-stream cipher.
package s20sc_pkg;

    // Number of double rounds per keystream block (range 4 to 10)
    localparam int unsigned DOUBLE_ROUNDS = 10;
    localparam int unsigned ROUND_W       = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    // "expand 32-byte k" words
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // Quarter-round rotate amounts
    localparam int unsigned ROT_0 = 7;
    localparam int unsigned ROT_1 = 9;
    localparam int unsigned ROT_2 = 13;
    localparam int unsigned ROT_3 = 18;

    // Configuration register indexes
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NONCE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_START   = 3'd5;

    // Quarter-round operand slots
    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;
    localparam logic [1:0] SLOT_C = 2'd2;
    localparam logic [1:0] SLOT_D = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       message_done;
    } out_item_t;

    // Matrix word index for one slot of a quarter-round;
    // quarters 0..3 are the column round, 4..7 the row round
    function automatic logic [3:0] qr_slot(input logic [2:0] q, input logic [1:0] slot);
        logic [15:0] idx;
        unique case (q)
            3'd0: idx = 16'h048C;
            3'd1: idx = 16'h59D1;
            3'd2: idx = 16'hAE26;
            3'd3: idx = 16'hF37B;
            3'd4: idx = 16'h0123;
            3'd5: idx = 16'h5674;
            3'd6: idx = 16'hAB89;
            3'd7: idx = 16'hFCDE;
            default: idx = 16'h048C;
        endcase
        unique case (slot)
            SLOT_A:  return idx[15:12];
            SLOT_B:  return idx[11:8];
            SLOT_C:  return idx[7:4];
            SLOT_D:  return idx[3:0];
            default: return idx[3:0];
        endcase
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // Input matrix word from key, nonce and block counter
    function automatic logic [31:0] init_word(
        input logic [3:0]  idx,
        input logic [63:0] key0,
        input logic [63:0] key1,
        input logic [63:0] key2,
        input logic [63:0] key3,
        input logic [63:0] nonce,
        input logic [63:0] ctr
    );
        unique case (idx)
            4'd0:  return SIGMA_0;
            4'd1:  return key0[31:0];
            4'd2:  return key0[63:32];
            4'd3:  return key1[31:0];
            4'd4:  return key1[63:32];
            4'd5:  return SIGMA_1;
            4'd6:  return nonce[31:0];
            4'd7:  return nonce[63:32];
            4'd8:  return ctr[31:0];
            4'd9:  return ctr[63:32];
            4'd10: return SIGMA_2;
            4'd11: return key2[31:0];
            4'd12: return key2[63:32];
            4'd13: return key3[31:0];
            4'd14: return key3[63:32];
            4'd15: return SIGMA_3;
            default: return SIGMA_0;
        endcase
    endfunction

endpackage

FILE: rtl/salsa20_stream_cipher_top.sv
// Salsa20/20 byte-stream cipher: one shared add-rotate-xor unit under a small sequencer.
// Within a block an item is accepted (word read into the result register), then its output
// is registered once the output register is free. At byte position 0 a new block is built
// first: 16 loads, 80 quarter-rounds (two reads, four steps), 16 feed-forward adds, a read.
// One item in flight at a time; ready is high only while the sequencer waits for an item.
// Reset clears config, counter, position and control; the work store is not cleared.
module salsa20_stream_cipher_top
    import s20sc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // item input
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    // item output
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_QRD_AB = 4'd2;
    localparam logic [3:0] ST_QRD_CD = 4'd3;
    localparam logic [3:0] ST_QSTEP  = 4'd4;
    localparam logic [3:0] ST_FF_RD  = 4'd5;
    localparam logic [3:0] ST_FF_WR  = 4'd6;
    localparam logic [3:0] ST_READ   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    // control state
    logic [3:0]         state_reg, state_next;
    logic [3:0]         widx_reg, widx_next;
    logic [2:0]         qnum_reg, qnum_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [1:0]         step_reg, step_next;
    logic [5:0]         pos_reg, pos_next;
    logic [63:0]        ctr_reg, ctr_next;
    logic               out_valid_reg, out_valid_next;

    // configuration registers
    logic [63:0] key0_reg, key0_next;
    logic [63:0] key1_reg, key1_next;
    logic [63:0] key2_reg, key2_next;
    logic [63:0] key3_reg, key3_next;
    logic [63:0] nonce_reg, nonce_next;
    logic [63:0] start_reg, start_next;

    // payload
    logic [31:0] work_mem [16];
    logic [31:0] qa_reg, qb_reg, qc_reg, qd_reg;
    logic [31:0] word_reg;
    in_item_t    item_reg;
    out_item_t   out_item_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 in_fire;
    logic                 out_load;
    logic [31:0]          init_val;
    logic [31:0]          op_x, op_y, op_t;
    logic [31:0]          sum;
    logic [31:0]          rot;
    logic [31:0]          unit_res;
    logic [3:0]           tgt_idx;
    logic                 wr_en;
    logic [3:0]           wr_addr;
    logic [31:0]          wr_data;
    logic [7:0]           ks_byte;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign cfg_idx   = paddr[5:3];
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_load  = (state_reg == ST_OUT) & (~out_valid_reg | out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // register read-back
    always_comb
    begin
        unique case (cfg_idx)
            REG_KEY_0: prdata = key0_reg;
            REG_KEY_1: prdata = key1_reg;
            REG_KEY_2: prdata = key2_reg;
            REG_KEY_3: prdata = key3_reg;
            REG_NONCE: prdata = nonce_reg;
            REG_START: prdata = start_reg;
            default:   prdata = 64'd0;
        endcase
    end

    assign init_val = init_word(widx_reg, key0_reg, key1_reg, key2_reg, key3_reg,
                                nonce_reg, ctr_reg);

    // shared unit: operand selection per quarter-round step, or feed-forward add
    always_comb
    begin
        op_x    = qa_reg;
        op_y    = qd_reg;
        op_t    = qb_reg;
        tgt_idx = qr_slot(qnum_reg, SLOT_B);
        unique case (step_reg)
            2'd0:
            begin
                op_x    = qa_reg;
                op_y    = qd_reg;
                op_t    = qb_reg;
                tgt_idx = qr_slot(qnum_reg, SLOT_B);
            end
            2'd1:
            begin
                op_x    = qb_reg;
                op_y    = qa_reg;
                op_t    = qc_reg;
                tgt_idx = qr_slot(qnum_reg, SLOT_C);
            end
            2'd2:
            begin
                op_x    = qc_reg;
                op_y    = qb_reg;
                op_t    = qd_reg;
                tgt_idx = qr_slot(qnum_reg, SLOT_D);
            end
            2'd3:
            begin
                op_x    = qd_reg;
                op_y    = qc_reg;
                op_t    = qa_reg;
                tgt_idx = qr_slot(qnum_reg, SLOT_A);
            end
            default:
            begin
                op_x    = qa_reg;
                op_y    = qd_reg;
                op_t    = qb_reg;
                tgt_idx = qr_slot(qnum_reg, SLOT_B);
            end
        endcase
        if (state_reg == ST_FF_WR)
        begin
            op_x = qa_reg;
            op_y = init_val;
        end
    end

    assign sum = op_x + op_y;

    always_comb
    begin
        unique case (step_reg)
            2'd0:    rot = rotl32(sum, ROT_0);
            2'd1:    rot = rotl32(sum, ROT_1);
            2'd2:    rot = rotl32(sum, ROT_2);
            2'd3:    rot = rotl32(sum, ROT_3);
            default: rot = rotl32(sum, ROT_0);
        endcase
    end

    assign unit_res = op_t ^ rot;

    // work store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = widx_reg;
        wr_data = init_val;
        unique case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = widx_reg;
                wr_data = init_val;
            end
            ST_QSTEP:
            begin
                wr_en   = 1'b1;
                wr_addr = tgt_idx;
                wr_data = unit_res;
            end
            ST_FF_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = widx_reg;
                wr_data = sum;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_addr = widx_reg;
                wr_data = init_val;
            end
        endcase
    end

    // keystream byte from the registered word
    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd0:    ks_byte = word_reg[7:0];
            2'd1:    ks_byte = word_reg[15:8];
            2'd2:    ks_byte = word_reg[23:16];
            2'd3:    ks_byte = word_reg[31:24];
            default: ks_byte = word_reg[7:0];
        endcase
    end

    // sequencer and configuration next state
    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        qnum_next      = qnum_reg;
        round_next     = round_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        ctr_next       = ctr_reg;
        out_valid_next = out_valid_reg;
        key0_next      = key0_reg;
        key1_next      = key1_reg;
        key2_next      = key2_reg;
        key3_next      = key3_reg;
        nonce_next     = nonce_reg;
        start_next     = start_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (pos_reg == 6'd0)
                    begin
                        state_next = ST_INIT;
                        widx_next  = 4'd0;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_INIT:
            begin
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'hF)
                begin
                    state_next = ST_QRD_AB;
                    qnum_next  = 3'd0;
                    round_next = '0;
                end
            end
            ST_QRD_AB:
                state_next = ST_QRD_CD;
            ST_QRD_CD:
            begin
                state_next = ST_QSTEP;
                step_next  = 2'd0;
            end
            ST_QSTEP:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    qnum_next = qnum_reg + 3'd1;
                    if (qnum_reg == 3'd7 && round_reg == ROUND_W'(DOUBLE_ROUNDS - 1))
                    begin
                        state_next = ST_FF_RD;
                        widx_next  = 4'd0;
                    end
                    else
                    begin
                        state_next = ST_QRD_AB;
                        if (qnum_reg == 3'd7)
                            round_next = round_reg + ROUND_W'(1);
                    end
                end
            end
            ST_FF_RD:
                state_next = ST_FF_WR;
            // each word is read back before its feed-forward add
            ST_FF_WR:
            begin
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'hF)
                    state_next = ST_READ;
                else
                    state_next = ST_FF_RD;
            end
            ST_READ:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (pos_reg == 6'd63 || item_reg.end_of_message)
                    begin
                        pos_next = 6'd0;
                        ctr_next = ctr_reg + 64'd1;
                    end
                    else
                        pos_next = pos_reg + 6'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // register writes; a counter write reloads the running counter
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_KEY_0: key0_next  = pwdata;
                REG_KEY_1: key1_next  = pwdata;
                REG_KEY_2: key2_next  = pwdata;
                REG_KEY_3: key3_next  = pwdata;
                REG_NONCE: nonce_next = pwdata;
                REG_START:
                begin
                    start_next = pwdata;
                    ctr_next   = pwdata;
                end
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            widx_reg      <= 4'd0;
            qnum_reg      <= 3'd0;
            round_reg     <= '0;
            step_reg      <= 2'd0;
            pos_reg       <= 6'd0;
            ctr_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
            key0_reg      <= 64'd0;
            key1_reg      <= 64'd0;
            key2_reg      <= 64'd0;
            key3_reg      <= 64'd0;
            nonce_reg     <= 64'd0;
            start_reg     <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            qnum_reg      <= qnum_next;
            round_reg     <= round_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
            key0_reg      <= key0_next;
            key1_reg      <= key1_next;
            key2_reg      <= key2_next;
            key3_reg      <= key3_next;
            nonce_reg     <= nonce_next;
            start_reg     <= start_next;
        end
    end

    // work store (holds the keystream block once finished) and datapath registers
    always_ff @(posedge clk)
    begin
        if (wr_en)
            work_mem[wr_addr] <= wr_data;

        if (state_reg == ST_QRD_AB)
        begin
            qa_reg <= work_mem[qr_slot(qnum_reg, SLOT_A)];
            qb_reg <= work_mem[qr_slot(qnum_reg, SLOT_B)];
        end

        if (state_reg == ST_QRD_CD)
        begin
            qc_reg <= work_mem[qr_slot(qnum_reg, SLOT_C)];
            qd_reg <= work_mem[qr_slot(qnum_reg, SLOT_D)];
        end

        // quarter-round step result lands in its local copy too
        if (state_reg == ST_QSTEP)
        begin
            unique case (step_reg)
                2'd0:    qb_reg <= unit_res;
                2'd1:    qc_reg <= unit_res;
                2'd2:    qd_reg <= unit_res;
                2'd3:    qa_reg <= unit_res;
                default: qb_reg <= unit_res;
            endcase
        end

        if (state_reg == ST_FF_RD)
            qa_reg <= work_mem[widx_reg];

        if (in_fire || state_reg == ST_READ)
            word_reg <= work_mem[pos_reg[5:2]];

        if (in_fire)
            item_reg <= in_item;

        if (out_load)
        begin
            out_item_reg.out_byte     <= item_reg.data_byte ^ ks_byte;
            out_item_reg.message_done <= item_reg.end_of_message;
        end
    end

endmodule
